// ===== rtl/core/pums_pkg.sv =====
`timescale 1ns / 1ps
// Package for the power unit mode sequencer: mode codes, event codes and word widths.
// Depends on nothing. Used by power_unit_mode_sequencer_unit.

package pums_pkg;

  localparam int unsigned ModeW  = 5;
  localparam int unsigned EventW = 5;

  typedef logic [ModeW-1:0]  mode_t;
  typedef logic [EventW-1:0] event_t;

  // Operating modes
  localparam mode_t MODE_OFF      = 5'd0;
  localparam mode_t MODE_FIRE     = 5'd1;
  localparam mode_t MODE_IDLE     = 5'd2;
  localparam mode_t MODE_TEST     = 5'd3;
  localparam mode_t MODE_EGT      = 5'd4;
  localparam mode_t MODE_OVSPD    = 5'd5;
  localparam mode_t MODE_START    = 5'd6;
  localparam mode_t MODE_AUTO     = 5'd7;
  localparam mode_t MODE_EMSTART  = 5'd8;
  localparam mode_t MODE_RUN      = 5'd9;
  localparam mode_t MODE_RUN_LIM  = 5'd10;
  localparam mode_t MODE_MES      = 5'd11;
  localparam mode_t MODE_MES_LIM  = 5'd12;
  localparam mode_t MODE_GEN      = 5'd13;
  localparam mode_t MODE_GEN_LIM  = 5'd14;
  localparam mode_t MODE_BLEED    = 5'd15;
  localparam mode_t MODE_LOAD     = 5'd16;
  localparam mode_t MODE_RELIGHT  = 5'd17;
  localparam mode_t MODE_FLAMEOUT = 5'd18;
  localparam mode_t MODE_EMSHUT   = 5'd19;
  localparam mode_t MODE_COOL     = 5'd20;
  localparam mode_t MODE_NSHUT    = 5'd21;
  localparam mode_t MODE_INDEF    = 5'd22;

  // Event codes
  localparam event_t EV_FIRE      = 5'd0;
  localparam event_t EV_OVHEAT    = 5'd1;
  localparam event_t EV_OVSPD     = 5'd2;
  localparam event_t EV_FLAMEOUT  = 5'd3;
  localparam event_t EV_RELIGHT   = 5'd4;
  localparam event_t EV_RESTORED  = 5'd5;
  localparam event_t EV_EMSHUT    = 5'd6;
  localparam event_t EV_PWR_OFF   = 5'd7;
  localparam event_t EV_PWR_ON    = 5'd8;
  localparam event_t EV_TEST      = 5'd9;
  localparam event_t EV_START     = 5'd10;
  localparam event_t EV_AUTO      = 5'd11;
  localparam event_t EV_EMSTART   = 5'd12;
  localparam event_t EV_TEST_DONE = 5'd13;
  localparam event_t EV_OK        = 5'd14;
  localparam event_t EV_FAIL      = 5'd15;
  localparam event_t EV_ABORT     = 5'd16;
  localparam event_t EV_BLEED_ON  = 5'd17;
  localparam event_t EV_GEN_ON    = 5'd18;
  localparam event_t EV_MES_ON    = 5'd19;
  localparam event_t EV_NSHUT     = 5'd20;
  localparam event_t EV_BLEED_OFF = 5'd21;
  localparam event_t EV_GEN_OFF   = 5'd22;
  localparam event_t EV_MES_OFF   = 5'd23;
  localparam event_t EV_COOL_TO   = 5'd24;
  localparam event_t EV_STOPPED   = 5'd25;

endpackage

// ===== rtl/core/power_unit_mode_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Power unit mode sequencer: input word register, next-mode logic, result register.
// Depends on pums_pkg for the mode and event codes.
//
// Usage
//   Input channel: event_req with in_valid / in_stall. A word is taken at a rising
//   edge with in_valid high and in_stall low.
//   Output channel: next_mode and mode_changed with out_valid / out_stall. One result
//   word leaves for every event word taken, in order.
//   An accepted event passes through the input register, then the result register,
//   before out_valid rises.
//   Throughput: one event per cycle while out_stall is low; the next-mode lookup is a
//   small decode of the held mode and the event and fits between the two registers.
//   The mode register moves on when an event passes into the result register.
//   Reset (rst, synchronous) empties both registers and sets the mode to off.
//   When the receiver stalls, the result word holds; the input register still takes
//   one more event and in_stall rises only once both registers are full.

module power_unit_mode_sequencer_unit
  import pums_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [EventW-1:0] event_req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ModeW-1:0]  next_mode,
  output logic              mode_changed
);

  logic   s1_valid;
  event_t s1_event;
  mode_t  unit_mode;
  mode_t  unit_mode_next;
  logic   adv;

  // Fault rules: take priority over normal sequencing, each valid only in the modes its condition allows
  function automatic logic [ModeW:0] fault_rule(input mode_t m, input event_t e);
    logic  hit;
    mode_t n;
    hit = 1'b0;
    n   = m;
    case (e)
      EV_FIRE: begin
        if (m != MODE_OFF) begin
          hit = 1'b1; n = MODE_FIRE;
        end
      end
      EV_OVHEAT, EV_OVSPD: begin
        if (m != MODE_OFF && m != MODE_IDLE && m != MODE_TEST && m != MODE_FIRE) begin
          hit = 1'b1;
          n   = (e == EV_OVHEAT) ? MODE_EGT : MODE_OVSPD;
        end
      end
      EV_FLAMEOUT: begin
        if (m == MODE_START || m == MODE_AUTO || m == MODE_EMSTART || m == MODE_RUN ||
            m == MODE_RUN_LIM || m == MODE_MES || m == MODE_MES_LIM || m == MODE_GEN ||
            m == MODE_GEN_LIM || m == MODE_BLEED || m == MODE_LOAD ||
            m == MODE_RELIGHT) begin
          hit = 1'b1; n = MODE_FLAMEOUT;
        end
      end
      EV_RELIGHT: begin
        if (m == MODE_FLAMEOUT) begin
          hit = 1'b1; n = MODE_RELIGHT;
        end
      end
      EV_RESTORED: begin
        if (m == MODE_RELIGHT) begin
          hit = 1'b1; n = MODE_RUN_LIM;
        end
      end
      EV_EMSHUT: begin
        if (m == MODE_FIRE || m == MODE_EGT || m == MODE_OVSPD || m == MODE_FLAMEOUT) begin
          hit = 1'b1; n = MODE_EMSHUT;
        end
      end
      EV_PWR_OFF: begin
        if (m == MODE_EMSHUT) begin
          hit = 1'b1; n = MODE_OFF;
        end
      end
      default: ;
    endcase
    return {hit, n};
  endfunction

  // Normal sequencing; an unmatched event keeps the mode
  function automatic mode_t normal_rule(input mode_t m, input event_t e);
    mode_t n;
    n = m;
    case (m)
      MODE_OFF: begin
        if (e == EV_PWR_ON) n = MODE_IDLE;
      end
      MODE_IDLE: begin
        if (e == EV_TEST) n = MODE_TEST;
        else if (e == EV_START) n = MODE_START;
        else if (e == EV_AUTO) n = MODE_AUTO;
        else if (e == EV_EMSTART) n = MODE_EMSTART;
        else if (e == EV_PWR_OFF) n = MODE_OFF;
      end
      MODE_TEST: begin
        if (e == EV_TEST_DONE) n = MODE_IDLE;
      end
      MODE_START: begin
        if (e == EV_OK) n = MODE_RUN;
        else if (e == EV_FAIL || e == EV_ABORT) n = MODE_IDLE;
      end
      MODE_AUTO: begin
        if (e == EV_OK) n = MODE_RUN;
        else if (e == EV_FAIL) n = MODE_IDLE;
      end
      MODE_EMSTART: begin
        if (e == EV_OK) n = MODE_RUN_LIM;
        else if (e == EV_ABORT) n = MODE_IDLE;
      end
      MODE_RUN: begin
        if (e == EV_BLEED_ON) n = MODE_BLEED;
        else if (e == EV_GEN_ON) n = MODE_GEN;
        else if (e == EV_MES_ON) n = MODE_MES;
        else if (e == EV_NSHUT) n = MODE_COOL;
      end
      MODE_BLEED: begin
        if (e == EV_BLEED_OFF) n = MODE_RUN;
        else if (e == EV_GEN_ON) n = MODE_LOAD;
        else if (e == EV_MES_ON) n = MODE_MES;
      end
      MODE_GEN: begin
        if (e == EV_BLEED_ON) n = MODE_LOAD;
        else if (e == EV_GEN_OFF) n = MODE_RUN;
        else if (e == EV_MES_ON) n = MODE_MES;
      end
      MODE_LOAD: begin
        if (e == EV_BLEED_OFF) n = MODE_GEN;
        else if (e == EV_GEN_OFF) n = MODE_BLEED;
        else if (e == EV_MES_ON) n = MODE_MES;
      end
      MODE_MES: begin
        if (e == EV_MES_OFF) n = MODE_RUN;
      end
      MODE_RUN_LIM: begin
        if (e == EV_GEN_ON) n = MODE_GEN_LIM;
        else if (e == EV_MES_ON) n = MODE_MES_LIM;
        else if (e == EV_NSHUT) n = MODE_COOL;
      end
      MODE_GEN_LIM: begin
        if (e == EV_GEN_OFF) n = MODE_RUN_LIM;
        else if (e == EV_MES_ON) n = MODE_MES_LIM;
      end
      MODE_MES_LIM: begin
        if (e == EV_MES_OFF) n = MODE_RUN_LIM;
      end
      MODE_COOL: begin
        if (e == EV_COOL_TO) n = MODE_NSHUT;
      end
      MODE_NSHUT: begin
        if (e == EV_STOPPED) n = MODE_IDLE;
      end
      default: ;
    endcase
    return n;
  endfunction

  // Next mode for the held event; indefinite and unused codes are absorbing
  always_comb begin
    logic [ModeW:0] f;
    f = fault_rule(unit_mode, s1_event);
    if (unit_mode >= MODE_INDEF) begin
      unit_mode_next = unit_mode;
    end else if (f[ModeW]) begin
      unit_mode_next = f[ModeW-1:0];
    end else begin
      unit_mode_next = normal_rule(unit_mode, s1_event);
    end
  end

  // Handshake: result register frees when empty or taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;

  // Input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_event <= event_req;
    end
  end

  // Mode register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_mode <= MODE_OFF;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        unit_mode <= unit_mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      next_mode    <= unit_mode_next;
      mode_changed <= (unit_mode_next != unit_mode);
    end
  end

  // Checks
  a_result_tracks_mode: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv) |=> (out_valid && next_mode == unit_mode))
    else $error("result word does not match the mode register");

  a_mode_in_range: assert property (@(posedge clk) disable iff (rst)
    unit_mode <= MODE_INDEF)
    else $error("mode register holds an unused code");

  a_indef_absorbing: assert property (@(posedge clk) disable iff (rst)
    (unit_mode == MODE_INDEF) |=> (unit_mode == MODE_INDEF))
    else $error("left the indefinite mode");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free register");

  a_mode_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && adv) |=> $stable(unit_mode))
    else $error("mode changed with no event passing");

endmodule
